// ===== design/policy_group_prefix_match_table_defines.svh =====
// Assertion macros for the policy group prefix match table checker.
`ifndef POLICY_GROUP_PREFIX_MATCH_TABLE_DEFINES_SVH
`define POLICY_GROUP_PREFIX_MATCH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PGPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PGPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pgpm_pkg.sv =====
// Shared types, constants and helper functions for the prefix match table.
`default_nettype none

package pgpm_pkg;

   localparam int MAX_ENTRIES = 4096;
   localparam int MAX_GROUPS  = 1024;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 6;
   localparam int POLICY_W    = 10;
   localparam int MODE_W      = 2;
   localparam int ENTRY_IDX_W = $clog2(MAX_ENTRIES);
   localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int GROUP_W     = $clog2(MAX_GROUPS);

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD     = 2'd0,
      MODE_DISABLE = 2'd1,
      MODE_QUERY   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [POLICY_W-1:0] policy_id;
      logic [ADDR_W-1:0]   first_address;
      logic [LEN_W-1:0]    prefix_len;
      logic [ADDR_W-1:0]   second_address;
   } req_type;

   typedef struct packed {
      logic verdict;
      logic full_error;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  network;
      logic [LEN_W-1:0]   length;
      logic [GROUP_W-1:0] group;
      logic               disabled;
   } entry_type;

   // One match-set update per walked entry during a query
   typedef struct packed {
      logic               valid;
      logic [GROUP_W-1:0] group;
      logic               hit_first;
      logic               hit_second;
   } set_upd_type;

   // One cleared group per cycle during the clearing sweep
   typedef struct packed {
      logic               valid;
      logic [GROUP_W-1:0] index;
   } set_clr_type;

   function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] res;
      res = (len > LEN_W'(ADDR_W)) ? LEN_W'(ADDR_W) : len;
      return res;
   endfunction

   // Length zero gives an all-zero mask, full length gives all ones.
   function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] res;
      res = ~({ADDR_W{1'b1}} >> clamp_len(len));
      return res;
   endfunction

   function automatic logic [GROUP_W-1:0] group_of(input logic [POLICY_W-1:0] id);
      logic [GROUP_W-1:0] res;
      res = GROUP_W'(id % MAX_GROUPS);
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== design/pgpm_group_set.sv =====
// Per-group match-set memory with read-modify-write, forwarding and pair detection.
`default_nettype none

module pgpm_group_set
   import pgpm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire set_upd_type upd,
   input  wire set_clr_type clr,
   output logic             pair_hit
);

   // bit 1: matched first address, bit 0: matched second address
   logic [1:0] set_mem [MAX_GROUPS];

   logic [1:0]         rd_q_ff;
   set_upd_type        stage_ff;
   logic               wr_vld_ff;
   logic [GROUP_W-1:0] wr_group_ff;
   logic [1:0]         wr_val_ff;

   logic               we;
   logic [GROUP_W-1:0] wa;
   logic [1:0]         wd;
   logic [1:0]         cur;

   // Take the value written last cycle when the read raced it
   always_comb begin
      cur = (wr_vld_ff && wr_group_ff == stage_ff.group) ? wr_val_ff : rd_q_ff;
   end

   always_comb begin
      we = 1'b0;
      wa = stage_ff.group;
      wd = cur | {stage_ff.hit_first, stage_ff.hit_second};
      if (clr.valid) begin
         we = 1'b1;
         wa = clr.index;
         wd = 2'b00;
      end else if (stage_ff.valid) begin
         we = 1'b1;
      end
   end

   assign pair_hit = stage_ff.valid && (&wd);

   always_ff @(posedge clock) begin
      if (we) begin
         set_mem[wa] <= wd;
      end
      rd_q_ff     <= set_mem[upd.group];
      wr_group_ff <= wa;
      wr_val_ff   <= wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= '0;
         wr_vld_ff <= 1'b0;
      end else begin
         stage_ff  <= upd;
         wr_vld_ff <= we;
      end
   end

endmodule

`default_nettype wire

// ===== design/policy_group_prefix_match_table.sv =====
// Top level of the policy group IPv4 prefix match table.
//
// Usage: one input channel (start/busy) and one result channel (rsp_strobe).
// An item is taken at a clock edge where start is high and busy is low; each
// item gives exactly one result, shown for one cycle with rsp_strobe high.
// The receiver cannot stall: results must be taken when strobed.
// Add items and unused modes answer in the next cycle, busy stays low.
// Disable and query items walk the entry memory one entry a cycle through
// its single read port, then answer once the last reads and match-set
// updates have drained; with an empty table either answers in the next
// cycle and busy stays low. A query that walked then sweeps the group match
// sets back to zero, one group a cycle, with busy high from the cycle its
// result is strobed until the sweep ends. Busy is high during a walk too.
// After reset the same clearing sweep runs with busy high before the first
// item is taken; the entry table itself is never cleared, only the entry
// count.
`default_nettype none

module policy_group_prefix_match_table
   import pgpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_item,
   output logic         rsp_strobe,
   output rsp_type      rsp_item
);

   entry_type ent_mem [MAX_ENTRIES];

   state_type              state_ff, state_in;
   req_type                req_ff;
   logic [ENTRY_CNT_W-1:0] cnt_ff, cnt_in;
   logic [ENTRY_IDX_W-1:0] idx_ff, idx_in;
   logic [GROUP_W-1:0]     clr_idx_ff, clr_idx_in;
   logic                   b_vld_ff;
   logic [ENTRY_IDX_W-1:0] b_idx_ff;
   entry_type              ent_q_ff;
   logic                   upd_pend_ff;
   logic                   verdict_ff, verdict_in;
   logic                   rsp_vld_ff, rsp_vld_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   accept;
   logic                   walk_mode;
   logic                   last_issue;
   logic                   drained;
   logic                   clear_last;
   logic                   ent_re;
   logic                   ent_we;
   logic [ENTRY_IDX_W-1:0] ent_wa;
   entry_type              ent_wd;
   set_upd_type            upd;
   set_clr_type            clr;
   logic                   pair_hit;
   logic                   hit_first;
   logic                   hit_second;
   logic [ADDR_W-1:0]      ent_mask;

   assign busy       = (state_ff != ST_IDLE);
   assign accept     = start && !busy;
   assign walk_mode  = (req_item.mode == MODE_DISABLE) || (req_item.mode == MODE_QUERY);
   assign last_issue = (ENTRY_CNT_W'(idx_ff) == cnt_ff - ENTRY_CNT_W'(1));
   assign drained    = !b_vld_ff && !upd_pend_ff;
   assign clear_last = (clr_idx_ff == GROUP_W'(MAX_GROUPS - 1));

   assign ent_mask   = prefix_mask(ent_q_ff.length);
   assign hit_first  = !ent_q_ff.disabled
                       && ((req_ff.first_address & ent_mask) == ent_q_ff.network);
   assign hit_second = !ent_q_ff.disabled
                       && ((req_ff.second_address & ent_mask) == ent_q_ff.network);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && walk_mode && cnt_ff != '0) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (last_issue) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (drained) begin
               state_in = (req_ff.mode == MODE_QUERY) ? ST_CLEAR : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Outputs and datapath controls
   always_comb begin
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      clr_idx_in = '0;
      verdict_in = verdict_ff || pair_hit;
      rsp_vld_in = 1'b0;
      rsp_in     = '0;
      ent_re     = 1'b0;
      ent_we     = 1'b0;
      ent_wa     = b_idx_ff;
      ent_wd     = ent_q_ff;
      ent_wd.disabled = 1'b1;
      upd        = '0;
      clr        = '0;

      // Disable write-back and query updates for the entry read last cycle
      if (b_vld_ff && req_ff.mode == MODE_DISABLE
          && ent_q_ff.group == group_of(req_ff.policy_id)) begin
         ent_we = 1'b1;
      end
      if (b_vld_ff && req_ff.mode == MODE_QUERY) begin
         upd.valid      = 1'b1;
         upd.group      = ent_q_ff.group;
         upd.hit_first  = hit_first;
         upd.hit_second = hit_second;
      end

      case (state_ff)
         ST_CLEAR: begin
            clr.valid  = 1'b1;
            clr.index  = clr_idx_ff;
            clr_idx_in = clear_last ? '0 : clr_idx_ff + GROUP_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               verdict_in = 1'b0;
               if (req_item.mode == MODE_ADD) begin
                  rsp_vld_in = 1'b1;
                  if (cnt_ff == ENTRY_CNT_W'(MAX_ENTRIES)) begin
                     rsp_in.full_error = 1'b1;
                  end else begin
                     ent_we          = 1'b1;
                     ent_wa          = cnt_ff[ENTRY_IDX_W-1:0];
                     ent_wd.network  = req_item.first_address
                                       & prefix_mask(req_item.prefix_len);
                     ent_wd.length   = clamp_len(req_item.prefix_len);
                     ent_wd.group    = group_of(req_item.policy_id);
                     ent_wd.disabled = 1'b0;
                     cnt_in          = cnt_ff + ENTRY_CNT_W'(1);
                  end
               end else if (!walk_mode || cnt_ff == '0) begin
                  // Unused mode or empty table: answer at once
                  rsp_vld_in = 1'b1;
               end
            end
         end
         ST_WALK: begin
            ent_re = 1'b1;
            idx_in = idx_ff + ENTRY_IDX_W'(1);
         end
         ST_FLUSH: begin
            if (drained) begin
               rsp_vld_in     = 1'b1;
               rsp_in.verdict = (req_ff.mode == MODE_QUERY) && verdict_ff;
            end
         end
         default: begin
            rsp_vld_in = 1'b0;
         end
      endcase
   end

   // Entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (ent_we) begin
         ent_mem[ent_wa] <= ent_wd;
      end
      if (ent_re) begin
         ent_q_ff <= ent_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      idx_ff   <= idx_in;
      b_idx_ff <= idx_ff;
      rsp_ff   <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         clr_idx_ff  <= '0;
         b_vld_ff    <= 1'b0;
         upd_pend_ff <= 1'b0;
         verdict_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         clr_idx_ff  <= clr_idx_in;
         b_vld_ff    <= ent_re;
         upd_pend_ff <= upd.valid;
         verdict_ff  <= verdict_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   pgpm_group_set u_group_set (
      .clock    (clock),
      .reset    (reset),
      .upd      (upd),
      .clr      (clr),
      .pair_hit (pair_hit)
   );

   assign rsp_strobe = rsp_vld_ff;
   assign rsp_item   = rsp_ff;

endmodule

`default_nettype wire

// ===== design/pgpm_port_checker.sv =====
// Port-level checker for the prefix match table, bound to the top level.
`default_nettype none
`include "policy_group_prefix_match_table_defines.svh"

module pgpm_port_checker
   import pgpm_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    start,
   input wire logic    busy,
   input wire req_type req_item,
   input wire logic    rsp_strobe,
   input wire rsp_type rsp_item
);

   logic accept;

   assign accept = start && !busy;

   // Clearing sweep holds off items right after reset
   `PGPM_ASSERT_NOW(a_reset_busy, clock, reset, $past(reset), busy && !rsp_strobe, "no clearing sweep after reset")

   `PGPM_ASSERT_NEXT(a_add_answer, clock, reset, accept && req_item.mode == MODE_ADD, rsp_strobe && !rsp_item.verdict, "add transfer not answered next cycle")

   `PGPM_ASSERT_NEXT(a_unused_answer, clock, reset, accept && req_item.mode == MODE_UNUSED, rsp_strobe && !rsp_item.verdict && !rsp_item.full_error, "unused mode answer wrong")

   `PGPM_ASSERT_NOW(a_one_flag, clock, reset, rsp_strobe, !(rsp_item.verdict && rsp_item.full_error), "verdict and full flag together")

endmodule

bind policy_group_prefix_match_table pgpm_port_checker u_port_checker (.*);

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the policy group prefix match table.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pgpm_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = MAX_ENTRIES + MAX_GROUPS + 16;

   logic    clock    = 1'b0;
   logic    reset    = 1'b1;
   logic    start    = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   policy_group_prefix_match_table u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always #2 clock = ~clock;

   // Mirror of the entry table and the answers still owed by the block
   entry_type         table_entries [MAX_ENTRIES];
   int unsigned       entry_count = 0;
   rsp_type           verdict_q [$];
   rsp_type           oldest;
   int unsigned       mismatches = 0;
   int unsigned       cycles = 0;
   int unsigned       burst_left = 0;
   logic [ADDR_W-1:0] addr_pool [8];

   function automatic logic [ADDR_W-1:0] mask_for(logic [LEN_W-1:0] len);
      if (len == 0) return '0;
      if (len >= ADDR_W) return '1;
      return {ADDR_W{1'b1}} << (ADDR_W - len);
   endfunction

   // Apply one transfer to the mirrored table and return the answer it must produce
   function automatic rsp_type apply_table_item(req_type it);
      rsp_type               res;
      logic [GROUP_W-1:0]    grp;
      logic [LEN_W-1:0]      len;
      logic [MAX_GROUPS-1:0] first_hits;
      logic [MAX_GROUPS-1:0] second_hits;
      logic [ADDR_W-1:0]     m;
      res = '0;
      grp = GROUP_W'(it.policy_id % MAX_GROUPS);
      len = (it.prefix_len > ADDR_W) ? LEN_W'(ADDR_W) : it.prefix_len;
      case (mode_type'(it.mode))
         MODE_ADD: begin
            if (entry_count >= MAX_ENTRIES) begin
               res.full_error = 1'b1;
            end else begin
               table_entries[entry_count].network  = it.first_address & mask_for(len);
               table_entries[entry_count].length   = len;
               table_entries[entry_count].group    = grp;
               table_entries[entry_count].disabled = 1'b0;
               entry_count++;
            end
         end
         MODE_DISABLE: begin
            for (int i = 0; i < entry_count; i++)
               if (table_entries[i].group == grp) table_entries[i].disabled = 1'b1;
         end
         MODE_QUERY: begin
            first_hits  = '0;
            second_hits = '0;
            for (int i = 0; i < entry_count; i++) begin
               if (!table_entries[i].disabled) begin
                  m = mask_for(table_entries[i].length);
                  if ((it.first_address & m) == table_entries[i].network)
                     first_hits[table_entries[i].group] = 1'b1;
                  if ((it.second_address & m) == table_entries[i].network)
                     second_hits[table_entries[i].group] = 1'b1;
               end
            end
            res.verdict = |(first_hits & second_hits);
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type make_item(mode_type mode, int unsigned pid,
                                         logic [ADDR_W-1:0] first, int unsigned len,
                                         logic [ADDR_W-1:0] second);
      req_type it;
      it.mode           = mode;
      it.policy_id      = POLICY_W'(pid);
      it.first_address  = first;
      it.prefix_len     = LEN_W'(len);
      it.second_address = second;
      return it;
   endfunction

   function automatic req_type rand_fields();
      req_type it;
      it.mode           = MODE_W'($urandom);
      it.policy_id      = POLICY_W'($urandom);
      it.first_address  = $urandom;
      it.prefix_len     = LEN_W'($urandom);
      it.second_address = $urandom;
      return it;
   endfunction

   // Pick an address near one of a few bases so prefixes and queries overlap
   function automatic logic [ADDR_W-1:0] pool_addr();
      logic [ADDR_W-1:0] a;
      a = addr_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 3) != 0) a = a ^ ($urandom & 32'h0000_FFFF);
      return a;
   endfunction

   function automatic req_type random_policy_item();
      req_type it;
      int      r;
      int      len_kind;
      it = rand_fields();
      r  = $urandom_range(0, 99);
      if (r < 45) begin
         it.mode = MODE_ADD;
         if ($urandom_range(0, 9) != 0) it.policy_id = POLICY_W'($urandom_range(0, 7));
         it.first_address = pool_addr();
         len_kind = $urandom_range(0, 9);
         if (len_kind < 6)      it.prefix_len = LEN_W'($urandom_range(0, 16));
         else if (len_kind < 9) it.prefix_len = LEN_W'($urandom_range(17, 32));
         else                   it.prefix_len = LEN_W'($urandom_range(33, 63));
      end else if (r < 57) begin
         it.mode = MODE_DISABLE;
         if ($urandom_range(0, 9) != 0) it.policy_id = POLICY_W'($urandom_range(0, 7));
      end else if (r < 93) begin
         it.mode = MODE_QUERY;
         if ($urandom_range(0, 4) != 0) it.first_address = pool_addr();
         if ($urandom_range(0, 4) != 0) it.second_address = pool_addr();
      end
      return it;
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // Issue one transfer; the sender runs in bursts with random idle gaps
   task automatic send_item(req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            start    <= 1'b0;
            req_item <= rand_fields();
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      verdict_q = {verdict_q, apply_table_item(it)};
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("result strobed with no transfer outstanding");
         end else begin
            oldest = verdict_q.pop_front();
            if (rsp_item.verdict !== oldest.verdict)
               report_mismatch($sformatf("verdict %b, expected %b",
                                         rsp_item.verdict, oldest.verdict));
            if (rsp_item.full_error !== oldest.full_error)
               report_mismatch($sformatf("full_error %b, expected %b",
                                         rsp_item.full_error, oldest.full_error));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic test_empty_table();
      send_item(make_item(MODE_QUERY, 0, 32'h0000_0000, 0, 32'hFFFF_FFFF));
      send_item(make_item(MODE_DISABLE, 0, 32'h0000_0000, 0, 32'h0000_0000));
      send_item(make_item(MODE_UNUSED, 1023, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF));
   endtask

   task automatic test_prefix_lengths();
      send_item(make_item(MODE_ADD, 1023, 32'hFFFF_FFFF, 32, 32'h0000_0000));
      send_item(make_item(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF));
      send_item(make_item(MODE_QUERY, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFE));
      send_item(make_item(MODE_ADD, 1, 32'h0A00_1234, 8, 32'h0000_0000));
      // lengths above 32 clamp to an exact match
      send_item(make_item(MODE_ADD, 1, 32'hC0A8_0101, 63, 32'h0000_0000));
      send_item(make_item(MODE_QUERY, 0, 32'h0A12_3456, 0, 32'hC0A8_0101));
      send_item(make_item(MODE_QUERY, 0, 32'h0A12_3456, 0, 32'hC0A8_0100));
      // zero prefix matches everything, whatever network bits were given
      send_item(make_item(MODE_ADD, 2, 32'h1234_5678, 0, 32'h0000_0000));
      send_item(make_item(MODE_QUERY, 0, 32'h0000_0000, 0, 32'hFFFF_FFFF));
      send_item(make_item(MODE_ADD, 3, 32'h8000_0000, 1, 32'h0000_0000));
      send_item(make_item(MODE_ADD, 4, 32'h0000_0000, 33, 32'h0000_0000));
   endtask

   task automatic test_disable_and_readd();
      send_item(make_item(MODE_DISABLE, 2, 32'hFFFF_FFFF, 63, 32'hFFFF_FFFF));
      send_item(make_item(MODE_QUERY, 0, 32'h0000_0000, 0, 32'hFFFF_FFFF));
      send_item(make_item(MODE_DISABLE, 1023, 32'h0000_0000, 0, 32'h0000_0000));
      // entries added after a disable stay enabled
      send_item(make_item(MODE_ADD, 2, 32'hFFFF_0000, 0, 32'h0000_0000));
      send_item(make_item(MODE_QUERY, 0, 32'h0000_0000, 0, 32'hFFFF_FFFF));
      send_item(make_item(MODE_QUERY, 1023, 32'h8000_0001, 63, 32'h0A00_0000));
      send_item(make_item(MODE_UNUSED, 0, 32'h0000_0000, 40, 32'h0000_0000));
      send_item(make_item(MODE_QUERY, 0, 32'h0000_0000, 0, 32'h0000_0000));
   endtask

   task automatic test_random_traffic();
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      repeat (80) send_item(random_policy_item());
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_prefix_lengths();
      test_disable_and_readd();
      test_random_traffic();
      @(negedge clock);
      start <= 1'b0;
      wait (verdict_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && verdict_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/pgpm_pkg.sv
design/pgpm_group_set.sv
design/policy_group_prefix_match_table.sv
design/pgpm_port_checker.sv
verif/tb.sv
